// ===== rtl/mprq_pkg.sv =====
// Shared constants, types and helpers for the multilevel priority run queue.
// No dependencies; the core and the checker import this package.
`default_nettype none
package mprq_pkg;

  localparam int MAX_TASKS       = 32;
  localparam int PRIORITY_LEVELS = 32;
  localparam int TASK_W          = $clog2(MAX_TASKS);
  localparam int LVL_W           = $clog2(PRIORITY_LEVELS);

  typedef logic [TASK_W-1:0] task_t;
  typedef logic [LVL_W-1:0]  level_t;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_SWITCH  = 3'd2;
  localparam logic [2:0] OP_CHANGE  = 3'd3;
  localparam logic [2:0] OP_PEEK    = 3'd4;
  localparam logic [2:0] OP_SET_CUR = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_NOT_QUEUED = 2'd2;

  typedef struct packed {
    logic   found;
    level_t lvl;
  } pick_t;

  // Highest set bit of the nonempty vector.
  function automatic pick_t pick_highest(input logic [PRIORITY_LEVELS-1:0] ne);
    pick_t p;
    p = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (ne[i]) begin
        p.found = 1'b1;
        p.lvl   = LVL_W'(i);
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mprq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module mprq_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/multilevel_priority_run_queue_core.sv =====
// Top level of the multilevel priority run queue: sequencer and link memories.
// Depends on mprq_pkg and mprq_ram.
//
// Usage:
//   Requests enter on the in channel (in_valid/in_ready) with opcode, task_id,
//   task_priority and requeue_current. Each request yields exactly one result
//   on the out channel (out_valid/out_ready): result_task, preempt,
//   was_current and status.
//   One request is worked on at a time. The sequencer walks the linked lists
//   in five registered-read memories (level head, level tail, next, prev,
//   task level), one read or write step per cycle. Flag-only operations go
//   straight from accept to the result register; an unlink reads the links
//   (S_U_RD1, S_U_RD2) and writes them (S_U_WR); an append reads the tail
//   (S_A_RD) and writes (S_A_WR); a lookup picks the highest level (S_H_RD)
//   and reads its head (S_H_GOT), and a switch with requeue chains them all.
//   The next request is taken once the result sits in the output register.
//   Reset clears the nonempty and queued flag vectors, the current task and
//   level, and the handshake state; the memories need no clearing since each
//   entry is read only under a set flag. A stalled receiver holds the result
//   register; the sequencer then waits in its final step.
`default_nettype none
module multilevel_priority_run_queue_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] opcode,
  input  wire logic [4:0] task_id,
  input  wire logic [4:0] task_priority,
  input  wire logic       requeue_current,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [4:0] result_task,
  output logic            preempt,
  output logic            was_current,
  output logic      [1:0] status
);
  import mprq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_U_RD1, S_U_RD2, S_U_WR, S_A_RD, S_A_WR, S_H_RD, S_H_GOT, S_DONE
  } state_t;

  state_t state;

  // Request context.
  task_t  tsk;          // task to unlink and/or append
  level_t al;           // append level, or chosen level during lookup
  level_t ulv;          // level of the task being unlinked
  task_t  up, un;       // its prev and next links
  logic   do_unlink, do_append, do_pop, is_switch;
  logic [4:0] res;
  logic   pre, wc;
  logic [1:0] st;

  task_t  cur_task;
  level_t cur_level;
  logic [PRIORITY_LEVELS-1:0] nonempty;
  logic [MAX_TASKS-1:0]       queued;

  // Memory ports.
  logic   head_we, tail_we, next_we, prev_we, lvl_we;
  level_t head_waddr, tail_waddr, head_raddr, tail_raddr;
  task_t  head_wdata, tail_wdata, head_q, tail_q;
  task_t  next_waddr, next_wdata, prev_waddr, prev_wdata, lvl_waddr;
  level_t lvl_wdata, lvl_q;
  task_t  next_q, prev_q;

  // Decode of the incoming request.
  task_t  in_t;
  level_t in_lv;
  logic   in_named, in_bad;
  pick_t  pick;

  assign in_t     = TASK_W'(task_id);
  assign in_lv    = (32'(task_priority) >= 32'(PRIORITY_LEVELS)) ?
                    LVL_W'(PRIORITY_LEVELS - 1) : LVL_W'(task_priority);
  assign in_named = (opcode == OP_INSERT) || (opcode == OP_REMOVE) ||
                    (opcode == OP_CHANGE) || (opcode == OP_SET_CUR);
  assign in_bad   = in_named && (32'(task_id) >= 32'(MAX_TASKS));
  assign pick     = pick_highest(nonempty);
  assign in_ready = (state == S_IDLE);

  mprq_ram #(.WIDTH(TASK_W), .DEPTH(PRIORITY_LEVELS)) u_head (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_q));
  mprq_ram #(.WIDTH(TASK_W), .DEPTH(PRIORITY_LEVELS)) u_tail (
    .clk, .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .raddr(tail_raddr), .rdata(tail_q));
  mprq_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_next (
    .clk, .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(tsk), .rdata(next_q));
  mprq_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_prev (
    .clk, .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(tsk), .rdata(prev_q));
  mprq_ram #(.WIDTH(LVL_W), .DEPTH(MAX_TASKS)) u_lvl (
    .clk, .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(tsk), .rdata(lvl_q));

  // Memory steering per sequencer step. Reads are issued one step ahead of use;
  // no step reads an entry written in the same cycle.
  always_comb begin
    head_we = 1'b0; head_waddr = ulv; head_wdata = un;
    tail_we = 1'b0; tail_waddr = ulv; tail_wdata = up;
    next_we = 1'b0; next_waddr = up;  next_wdata = un;
    prev_we = 1'b0; prev_waddr = un;  prev_wdata = up;
    lvl_we  = 1'b0; lvl_waddr  = tsk; lvl_wdata  = al;
    head_raddr = (state == S_H_RD) ? pick.lvl : lvl_q;
    tail_raddr = (state == S_A_RD) ? al : lvl_q;
    case (state)
      S_U_WR: begin
        // Only entry: the level empties through its flag, no write.
        if (head_q == tsk && tail_q == tsk) begin
        end else if (head_q == tsk) begin
          head_we = 1'b1;
        end else if (tail_q == tsk) begin
          tail_we = 1'b1;
        end else begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
      end
      S_A_WR: begin
        lvl_we     = 1'b1;
        tail_we    = 1'b1;
        tail_waddr = al;
        tail_wdata = tsk;
        if (!nonempty[al]) begin
          head_we    = 1'b1;
          head_waddr = al;
          head_wdata = tsk;
        end else begin
          next_we    = 1'b1;
          next_waddr = tail_q;
          next_wdata = tsk;
          prev_we    = 1'b1;
          prev_waddr = tsk;
          prev_wdata = tail_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      nonempty  <= '0;
      queued    <= '0;
      cur_task  <= '0;
      cur_level <= '0;
      do_unlink <= 1'b0;
      do_append <= 1'b0;
      do_pop    <= 1'b0;
      is_switch <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads this cycle.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res       <= task_id;
            pre       <= 1'b0;
            wc        <= 1'b0;
            st        <= ST_OK;
            tsk       <= in_t;
            al        <= in_lv;
            do_unlink <= 1'b0;
            do_append <= 1'b0;
            do_pop    <= 1'b0;
            is_switch <= (opcode == OP_SWITCH);
            state     <= S_DONE;
            if (in_bad) begin
              st <= ST_NOT_QUEUED;
            end else begin
              case (opcode)
                OP_INSERT: begin
                  do_append <= 1'b1;
                  pre       <= (in_lv > cur_level);
                  state     <= queued[in_t] ? S_U_RD1 : S_A_RD;
                end
                OP_REMOVE: begin
                  if (in_t == cur_task) begin
                    wc <= 1'b1;
                  end else if (queued[in_t]) begin
                    state <= S_U_RD1;
                  end else begin
                    st <= ST_NOT_QUEUED;
                  end
                end
                OP_SWITCH, OP_PEEK: begin
                  do_pop <= 1'b1;
                  if (opcode == OP_SWITCH && requeue_current) begin
                    tsk       <= cur_task;
                    al        <= cur_level;
                    do_append <= 1'b1;
                    state     <= queued[cur_task] ? S_U_RD1 : S_A_RD;
                  end else begin
                    state <= S_H_RD;
                  end
                end
                OP_CHANGE: begin
                  if (in_t == cur_task) begin
                    cur_level <= in_lv;
                    wc        <= 1'b1;
                  end else if (queued[in_t]) begin
                    do_append <= 1'b1;
                    pre       <= (in_lv > cur_level);
                    state     <= S_U_RD1;
                  end else begin
                    st <= ST_NOT_QUEUED;
                  end
                end
                OP_SET_CUR: begin
                  cur_task  <= in_t;
                  cur_level <= in_lv;
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_U_RD1: begin
          state <= S_U_RD2;
        end
        S_U_RD2: begin
          // Latch the links; head and tail of the level are read now.
          ulv   <= lvl_q;
          up    <= prev_q;
          un    <= next_q;
          state <= S_U_WR;
        end
        S_U_WR: begin
          if (head_q == tsk && tail_q == tsk) begin
            nonempty[ulv] <= 1'b0;
          end
          queued[tsk] <= 1'b0;
          state <= do_append ? S_A_RD : (do_pop ? S_H_RD : S_DONE);
        end
        S_A_RD: begin
          state <= S_A_WR;
        end
        S_A_WR: begin
          nonempty[al] <= 1'b1;
          queued[tsk]  <= 1'b1;
          state        <= do_pop ? S_H_RD : S_DONE;
        end
        S_H_RD: begin
          if (pick.found) begin
            al    <= pick.lvl;
            state <= S_H_GOT;
          end else begin
            res   <= 5'(cur_task);
            st    <= ST_EMPTY;
            state <= S_DONE;
          end
        end
        S_H_GOT: begin
          res <= 5'(head_q);
          if (is_switch) begin
            // Pop the head: it becomes current, then unlink it.
            cur_task  <= head_q;
            cur_level <= al;
            tsk       <= head_q;
            do_append <= 1'b0;
            do_pop    <= 1'b0;
            state     <= S_U_RD1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            result_task <= res;
            preempt     <= pre;
            was_current <= wc;
            status      <= st;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mprq_checker.sv =====
// Port-level checker for the run queue core, attached by bind.
// Depends on mprq_pkg.
`default_nettype none
module mprq_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [4:0] result_task,
  input wire logic       preempt,
  input wire logic       was_current,
  input wire logic [1:0] status
);
  import mprq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_task) && $stable(status))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_EMPTY || status == ST_NOT_QUEUED)
    else $error("bad status code");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> !preempt && !was_current)
    else $error("flags set on empty queue");

endmodule

bind multilevel_priority_run_queue_core mprq_checker u_mprq_checker (.*);
`default_nettype wire
